>>> hw/rtl/dtoi_pkg.sv
package dtoi_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STATUS_W = 3;
    // Accumulator width: a 32-bit magnitude times ten plus one digit fits in 36 bits
    localparam int unsigned ACC_W = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;  // ' '
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;  // '\t'

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] MAG_SAT   = 32'h8000_0001;
    localparam logic [VALUE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BADCHAR  = 3'd1,
        ST_DOT      = 3'd2,
        ST_SIGN     = 3'd3,
        ST_SPACE    = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        t_status                   status;
    } t_out_item;

endpackage

>>> hw/rtl/decimal_text_to_integer.sv
// A request is held in the input register; its result, if it decides the line, is loaded
//   into the result register when the output is free.
// Throughput: one character per cycle unless a result stalls; the parse state is registered.
// A result waiting on the output holds the next character in the input register and
//   stalls the input until the result is taken.
// Reset (i_rst_n low, synchronous) clears the line state and both valid flags.
module decimal_text_to_integer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dtoi_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dtoi_pkg::t_out_item o_out_data
);

    logic                            r_in_valid;
    dtoi_pkg::t_in_item              r_in;
    logic                            r_out_valid;
    dtoi_pkg::t_out_item             r_out;

    logic                            r_line_done, n_line_done;
    logic [dtoi_pkg::VALUE_W-1:0]    r_mag, n_mag;
    logic                            r_neg, n_neg;
    logic                            r_sign_seen, n_sign_seen;
    logic                            r_digit_seen, n_digit_seen;
    logic                            r_point_seen, n_point_seen;
    logic                            r_gap_seen, n_gap_seen;

    logic                            w_fire;
    logic                            w_res_valid;
    dtoi_pkg::t_out_item             w_res;
    dtoi_pkg::t_out_item             w_emit;
    logic [dtoi_pkg::CHAR_W-1:0]     w_c;
    logic                            w_is_digit;
    logic [dtoi_pkg::CHAR_W-1:0]     w_digit;
    logic [dtoi_pkg::ACC_W-1:0]      w_acc;

    assign w_fire      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_c        = r_in.char_code;
    assign w_is_digit = (w_c >= dtoi_pkg::CH_ZERO) && (w_c <= dtoi_pkg::CH_NINE);
    assign w_digit    = w_c - dtoi_pkg::CH_ZERO;
    // mag * 10 + digit as (mag << 3) + (mag << 1) + digit
    assign w_acc = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                 + {{(dtoi_pkg::ACC_W - dtoi_pkg::CHAR_W){1'b0}}, w_digit};

    // Result for a successful decision, with the overflow check
    always_comb begin
        w_emit.value  = '0;
        w_emit.status = dtoi_pkg::ST_OK;
        if (r_neg ? (r_mag > dtoi_pkg::MAG_LIMIT) : (r_mag > dtoi_pkg::POS_LIMIT)) begin
            w_emit.status = dtoi_pkg::ST_OVERFLOW;
        end else begin
            w_emit.value = r_neg ? (~r_mag + 1'b1) : r_mag;
        end
    end

    always_comb begin
        n_line_done  = r_line_done;
        n_mag        = r_mag;
        n_neg        = r_neg;
        n_sign_seen  = r_sign_seen;
        n_digit_seen = r_digit_seen;
        n_point_seen = r_point_seen;
        n_gap_seen   = r_gap_seen;
        w_res_valid  = 1'b0;
        w_res        = w_emit;

        if (r_in.line_end) begin
            w_res_valid  = !r_line_done;
            // clear for the next line
            n_line_done  = 1'b0;
            n_mag        = '0;
            n_neg        = 1'b0;
            n_sign_seen  = 1'b0;
            n_digit_seen = 1'b0;
            n_point_seen = 1'b0;
            n_gap_seen   = 1'b0;
        end else if (!r_line_done) begin
            w_res.value = '0;
            priority if (w_is_digit) begin
                n_digit_seen = 1'b1;
                priority if (r_gap_seen) begin
                    w_res_valid  = 1'b1;
                    w_res.status = dtoi_pkg::ST_SPACE;
                end else if (r_point_seen) begin
                    w_res_valid = 1'b1;
                    w_res       = w_emit;
                end else begin
                    n_mag = (w_acc > {4'b0000, dtoi_pkg::MAG_LIMIT})
                          ? dtoi_pkg::MAG_SAT : w_acc[dtoi_pkg::VALUE_W-1:0];
                end
            end else if (w_c == dtoi_pkg::CH_DOT) begin
                if (r_point_seen) begin
                    w_res_valid  = 1'b1;
                    w_res.status = dtoi_pkg::ST_DOT;
                end
                n_point_seen = 1'b1;
            end else if (w_c == dtoi_pkg::CH_PLUS || w_c == dtoi_pkg::CH_MINUS) begin
                if (r_digit_seen || r_sign_seen) begin
                    w_res_valid  = 1'b1;
                    w_res.status = dtoi_pkg::ST_SIGN;
                end else begin
                    n_sign_seen = 1'b1;
                    if (w_c == dtoi_pkg::CH_MINUS) begin
                        n_neg = 1'b1;
                    end
                end
            end else if (w_c == dtoi_pkg::CH_SPACE || w_c == dtoi_pkg::CH_TAB) begin
                if (r_digit_seen || r_point_seen) begin
                    n_gap_seen = 1'b1;
                end
            end else begin
                w_res_valid  = 1'b1;
                w_res.status = dtoi_pkg::ST_BADCHAR;
            end
            if (w_res_valid) begin
                n_line_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_done  <= 1'b0;
            r_mag        <= '0;
            r_neg        <= 1'b0;
            r_sign_seen  <= 1'b0;
            r_digit_seen <= 1'b0;
            r_point_seen <= 1'b0;
            r_gap_seen   <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_line_done  <= n_line_done;
                r_mag        <= n_mag;
                r_neg        <= n_neg;
                r_sign_seen  <= n_sign_seen;
                r_digit_seen <= n_digit_seen;
                r_point_seen <= n_point_seen;
                r_gap_seen   <= n_gap_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_fire && w_res_valid) begin
            r_out <= w_res;
        end
    end

endmodule

>>> hw/rtl/dtoi_checker.sv
module dtoi_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input dtoi_pkg::t_out_item o_out_data,
    input logic                o_out_valid,
    input logic                i_out_ready
);

    // hold a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // error and overflow results carry a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != dtoi_pkg::ST_OK) |-> (o_out_data.value == '0))
        else $error("nonzero value with error status");

    // a fresh result traces back to an earlier accepted request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without a matching request");

    // an empty output never blocks the input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind decimal_text_to_integer dtoi_checker u_dtoi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_data  (o_out_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);
